/* rtl/multi_button_debounce_press_detect_core_defines.svh */
// Assertion helpers shared by the debounce core.
`ifndef MULTI_BUTTON_DEBOUNCE_PRESS_DETECT_CORE_DEFINES_SVH
`define MULTI_BUTTON_DEBOUNCE_PRESS_DETECT_CORE_DEFINES_SVH

// Plain property, checked on every clock edge outside of reset.
`define MBDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the following cycle.
`define MBDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mbdp_pkg.sv */
`timescale 1ns / 1ps

package mbdp_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int TIME_BITS   = 32;
  localparam int PIN_BITS    = 4;
  localparam int DEB_W       = 16;
  localparam int FIT_W       = 3;
  localparam int BTN_W       = 3;
  localparam int CFG_IDX_W   = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUTTONS_FITTED = 2'd2;

  // Reset values of the registers.
  localparam logic [DEB_W-1:0] RST_DEBOUNCE_MS    = 16'd50;
  localparam logic             RST_ACTIVE_LEVEL   = 1'b1;
  localparam logic [FIT_W-1:0] RST_BUTTONS_FITTED = 3'd4;

  typedef struct packed {
    logic [DEB_W-1:0] debounce_ms;
    logic             active_level;
    logic [FIT_W-1:0] buttons_fitted;
  } cfg_t;

  typedef struct packed {
    logic active;  // raw level equals the pressed level
    logic press;   // debounced level turns active in this poll
  } btn_stat_t;

endpackage

/* rtl/mbdp_cfg_regs.sv */
`timescale 1ns / 1ps

module mbdp_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mbdp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mbdp_pkg::DEB_W-1:0]     cfg_wdata_i,
  output mbdp_pkg::cfg_t                 cfg_o
);

  mbdp_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        mbdp_pkg::REG_DEBOUNCE_MS:    cfg_d.debounce_ms    = cfg_wdata_i;
        mbdp_pkg::REG_ACTIVE_LEVEL:   cfg_d.active_level   = cfg_wdata_i[0];
        mbdp_pkg::REG_BUTTONS_FITTED: cfg_d.buttons_fitted = cfg_wdata_i[mbdp_pkg::FIT_W-1:0];
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms    <= mbdp_pkg::RST_DEBOUNCE_MS;
      cfg_q.active_level   <= mbdp_pkg::RST_ACTIVE_LEVEL;
      cfg_q.buttons_fitted <= mbdp_pkg::RST_BUTTONS_FITTED;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/mbdp_channel.sv */
`timescale 1ns / 1ps

module mbdp_channel (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           lvl_i,
  input  logic [mbdp_pkg::TIME_BITS-1:0] now_i,
  input  mbdp_pkg::cfg_t                 cfg_i,
  input  logic                           upd_i,
  output mbdp_pkg::btn_stat_t            stat_o
);

  logic                           raw_q, raw_d;
  logic                           stable_q, stable_d;
  logic [mbdp_pkg::TIME_BITS-1:0] chg_q, chg_d;

  logic                           changed;
  logic [mbdp_pkg::TIME_BITS-1:0] elapsed;
  logic [mbdp_pkg::TIME_BITS-1:0] delay;
  logic                           flip;

  // A level that moved in this poll restarts its timer, so it can only
  // be accepted when it matches the previous raw sample.
  assign changed = (lvl_i != raw_q);
  assign elapsed = now_i - chg_q;
  assign delay   = {{(mbdp_pkg::TIME_BITS - mbdp_pkg::DEB_W){1'b0}}, cfg_i.debounce_ms};
  assign flip    = !changed && (elapsed > delay) && (lvl_i != stable_q);

  assign stat_o.active = (lvl_i == cfg_i.active_level);
  assign stat_o.press  = flip && stat_o.active;

  always_comb begin
    raw_d    = raw_q;
    stable_d = stable_q;
    chg_d    = chg_q;
    if (upd_i) begin
      raw_d = lvl_i;
      if (changed) begin
        chg_d = now_i;
      end
      if (flip) begin
        stable_d = lvl_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q    <= 1'b0;
      stable_q <= 1'b0;
      chg_q    <= '0;
    end else begin
      raw_q    <= raw_d;
      stable_q <= stable_d;
      chg_q    <= chg_d;
    end
  end

endmodule

/* rtl/multi_button_debounce_press_detect_core.sv */
`timescale 1ns / 1ps
// A poll moves from the input register to the result register; one poll per cycle
// unless the result channel stalls. The button scan is a single pass of logic
// between the input register and the result register.
// Reset: rst_ni is asynchronous and active low; it clears all button state and
// the idle timestamp and restores the configuration defaults (50 ms, high, 4).

module multi_button_debounce_press_detect_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [mbdp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mbdp_pkg::DEB_W-1:0]     cfg_wdata_i,
  // Poll input channel.
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [mbdp_pkg::TIME_BITS-1:0] now_ms_i,
  input  logic [mbdp_pkg::PIN_BITS-1:0]  pin_levels_i,
  // Result channel.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mbdp_pkg::BTN_W-1:0]     pressed_button_o,
  output logic [mbdp_pkg::TIME_BITS-1:0] idle_ms_o
);

  localparam int N = mbdp_pkg::NUM_BUTTONS;

  mbdp_pkg::cfg_t cfg;

  mbdp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The input register holds one poll; the result register holds one result.
  // The input register moves on whenever the result register is empty or is
  // being emptied, so a waiting result blocks new transactions only once the
  // input register is full as well.
  logic                           s1_valid_q, s1_valid_d;
  logic [mbdp_pkg::TIME_BITS-1:0] s1_now_q;
  logic [mbdp_pkg::PIN_BITS-1:0]  s1_pins_q;
  logic                           out_valid_q, out_valid_d;
  logic [mbdp_pkg::BTN_W-1:0]     out_btn_q, out_btn_d;
  logic [mbdp_pkg::TIME_BITS-1:0] out_idle_q, out_idle_d;
  logic [mbdp_pkg::TIME_BITS-1:0] last_act_q, last_act_d;

  logic advance;
  logic accept;
  logic fire;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign fire       = s1_valid_q && advance;

  assign s1_valid_d  = accept || (s1_valid_q && !advance);
  assign out_valid_d = fire || (out_valid_q && out_stall_i);

  // Per button: fitted, scanned in this poll, and press taken.
  mbdp_pkg::btn_stat_t stat [N];
  logic [N-1:0] fit;
  logic [N-1:0] scan;
  logic [N-1:0] take;
  logic [N-1:0] act;

  for (genvar g = 0; g < N; g++) begin : g_btn
    logic lvl;

    // Buttons beyond the pins that exist read as level zero.
    if (g < mbdp_pkg::PIN_BITS) begin : g_pin
      assign lvl = s1_pins_q[g];
    end else begin : g_nopin
      assign lvl = 1'b0;
    end

    // A fitted count above the number of buttons simply fits them all.
    assign fit[g] = {1'b0, cfg.buttons_fitted} > (mbdp_pkg::FIT_W + 1)'(g);

    // The scan walks upward and stops right after the first press.
    if (g == 0) begin : g_first
      assign scan[g] = fit[g];
    end else begin : g_next
      assign scan[g] = scan[g-1] && !stat[g-1].press && fit[g];
    end

    assign take[g] = scan[g] && stat[g].press;
    assign act[g]  = fit[g] && stat[g].active;

    mbdp_channel u_chan (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .lvl_i  (lvl),
      .now_i  (s1_now_q),
      .cfg_i  (cfg),
      .upd_i  (fire && scan[g]),
      .stat_o (stat[g])
    );
  end

  // Lowest taken press wins; at most one bit of take can be set anyway.
  always_comb begin
    out_btn_d = '0;
    for (int b = N - 1; b >= 0; b--) begin
      if (take[b]) begin
        out_btn_d = mbdp_pkg::BTN_W'(b + 1);
      end
    end
  end

  // Every fitted active pin refreshes the idle timestamp, even one above a
  // press that cut the scan short, so the idle time is then zero.
  assign last_act_d = (fire && (|act)) ? s1_now_q : last_act_q;
  assign out_idle_d = s1_now_q - last_act_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_act_q  <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      last_act_q  <= last_act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_now_q  <= now_ms_i;
      s1_pins_q <= pin_levels_i;
    end
    if (fire) begin
      out_btn_q  <= out_btn_d;
      out_idle_q <= out_idle_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pressed_button_o = out_btn_q;
  assign idle_ms_o        = out_idle_q;

  // A reported press, and whether its button lies within the fitted count.
  logic out_press;
  logic press_in_fit;
  assign out_press    = out_valid_o && (pressed_button_o != '0);
  assign press_in_fit = (pressed_button_o <= cfg.buttons_fitted);

`include "multi_button_debounce_press_detect_core_defines.svh"

  `MBDP_ASSERT(a_one_press, !s1_valid_q || $onehot0(take), "more than one press in a poll")
  `MBDP_ASSERT(a_press_idle, out_press |-> (idle_ms_o == '0), "press with nonzero idle time")
  `MBDP_ASSERT(a_press_fitted, out_press |-> press_in_fit, "press on a button not fitted")
  `MBDP_ASSERT_NEXT(a_hold_input, in_stall_o, s1_valid_q, "held poll lost under stall")

endmodule
